// File: rtl/core/bqsc_pkg.sv
// shared types and constants for the bounded queue server completion block
package bqsc_pkg;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 64;
  localparam int unsigned LIMIT_W = 6;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned FINISH_W = 48;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd63;
  localparam logic [FINISH_W-1:0] FINISH_MAX = {FINISH_W{1'b1}};

  typedef struct packed {
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] duration;
  } in_item_t;

  typedef struct packed {
    logic                accepted;
    logic [FINISH_W-1:0] finish_time;
  } out_item_t;

  typedef struct packed {
    logic keep;
    logic at_limit;
  } cell_status_t;

endpackage

// File: rtl/core/bqsc_cell.sv
// one queue cell: holds a finish time, retires itself, shifts toward older positions
module bqsc_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  logic                               push,
  input  logic [bqsc_pkg::TIME_W-1:0]        arrival_time,
  input  logic [bqsc_pkg::LIMIT_W-1:0]       queue_limit,
  input  logic                               prev_keep,
  input  logic [bqsc_pkg::FINISH_W-1:0]      prev_finish,
  output logic                               valid,
  output logic [bqsc_pkg::FINISH_W-1:0]      finish,
  output bqsc_pkg::cell_status_t             status
);

  localparam logic [31:0] IDX_VAL = 32'(IDX);

  logic keep;

  assign keep = valid &&
    (finish > {{(bqsc_pkg::FINISH_W - bqsc_pkg::TIME_W){1'b0}}, arrival_time});

  assign status.keep = keep;
  assign status.at_limit = keep &&
    ({{(32 - bqsc_pkg::LIMIT_W){1'b0}}, queue_limit} == IDX_VAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (step) begin
      valid <= push ? prev_keep : keep;
    end
  end

  always_ff @(posedge clk) begin
    if (step && push) begin
      finish <= prev_finish;
    end
  end

endmodule

// File: rtl/core/bounded_queue_server_completion.sv
// top level: admission control for a single server with a finite waiting buffer
//
//   channel | direction | handshake        | payload
//   in      | input     | in_valid/in_stall   | arrival_time, duration
//   out     | output    | out_valid/out_stall | accepted, finish_time
//   cfg     | input     | cfg_we              | queue_limit
//
// one item per cycle while in_stall is low; its result is in the output register on the next cycle
// all cells compare their finish time with the arrival time in the same cycle
// reset clears the cell valid bits and sets queue_limit to 63, no clearing pass
// input stalls only while a result waits in the output register under out_stall
module bounded_queue_server_completion #(
  parameter int unsigned QUEUE_DEPTH = bqsc_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bqsc_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bqsc_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [bqsc_pkg::LIMIT_W-1:0]      cfg_data
);

  logic [bqsc_pkg::LIMIT_W-1:0]  queue_limit;
  logic                          in_accept;
  logic                          push;
  logic                          reject;
  logic [QUEUE_DEPTH-1:0]        valid_vec;
  logic [QUEUE_DEPTH-1:0]        keep_vec;
  logic [QUEUE_DEPTH-1:0]        at_limit_vec;
  logic [bqsc_pkg::FINISH_W-1:0] finish_arr [QUEUE_DEPTH];
  bqsc_pkg::cell_status_t        status_arr [QUEUE_DEPTH];
  logic [bqsc_pkg::FINISH_W:0]   sum_queue;
  logic [bqsc_pkg::FINISH_W:0]   sum_arrival;
  logic [bqsc_pkg::FINISH_W:0]   sum_sel;
  logic [bqsc_pkg::FINISH_W-1:0] new_finish;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_limit <= bqsc_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      queue_limit <= cfg_data;
    end
  end

  // newest entry sits in cell 0, so a carried base is the first cell's finish
  assign sum_queue   = {1'b0, finish_arr[0]} +
                       (bqsc_pkg::FINISH_W + 1)'(in_data.duration);
  assign sum_arrival = (bqsc_pkg::FINISH_W + 1)'(in_data.arrival_time) +
                       (bqsc_pkg::FINISH_W + 1)'(in_data.duration);
  assign sum_sel     = keep_vec[0] ? sum_queue : sum_arrival;
  assign new_finish  = sum_sel[bqsc_pkg::FINISH_W] ? bqsc_pkg::FINISH_MAX
                                                   : sum_sel[bqsc_pkg::FINISH_W-1:0];

  assign reject = (|at_limit_vec) || keep_vec[QUEUE_DEPTH-1];
  assign push   = !reject;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                          prev_keep;
    logic [bqsc_pkg::FINISH_W-1:0] prev_finish;

    if (i == 0) begin : g_first
      assign prev_keep   = 1'b1;
      assign prev_finish = new_finish;
    end else begin : g_rest
      assign prev_keep   = keep_vec[i-1];
      assign prev_finish = finish_arr[i-1];
    end

    bqsc_cell #(
      .IDX(i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .step         (in_accept),
      .push         (push),
      .arrival_time (in_data.arrival_time),
      .queue_limit  (queue_limit),
      .prev_keep    (prev_keep),
      .prev_finish  (prev_finish),
      .valid        (valid_vec[i]),
      .finish       (finish_arr[i]),
      .status       (status_arr[i])
    );

    assign keep_vec[i]     = status_arr[i].keep;
    assign at_limit_vec[i] = status_arr[i].at_limit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data.accepted    <= push;
      out_data.finish_time <= push ? new_finish : '0;
    end
  end

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + QUEUE_DEPTH'(1))) == '0)
    else $error("cell valid bits are not a prefix");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.accepted |-> out_data.finish_time == '0)
    else $error("rejected item carries a finish time");

  a_accept_newest: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.accepted |-> valid_vec[0] && finish_arr[0] == out_data.finish_time)
    else $error("accepted finish time is not the newest entry");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> out_valid && $stable(valid_vec))
    else $error("queue changed while output was stalled");

endmodule
